@@ src/pswd_pkg.sv @@
package pswd_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned CountW   = 32;
  localparam int unsigned RidW     = 16;
  localparam int unsigned AckW     = 8;
  localparam int unsigned RemoteW  = 8;
  localparam int unsigned CfgW     = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 296;
  localparam int unsigned OutDataW = 72;

  localparam logic [CfgIdxW-1:0] REG_STALL_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CHURN_THRESH  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COOLDOWN      = 2'd2;

  localparam logic [CfgW-1:0] STALL_TIMEOUT_RST = 32'd3000;
  localparam logic [CfgW-1:0] CHURN_THRESH_RST  = 32'd8;
  localparam logic [CfgW-1:0] COOLDOWN_RST      = 32'd5000;

  typedef struct packed {
    logic [TimeW-1:0]   now_ms;
    logic               session_ok;
    logic [RidW-1:0]    resync_id;
    logic [AckW-1:0]    pending_acks;
    logic [RemoteW-1:0] remote_count;
    logic [FrameW-1:0]  epoch;
    logic [FrameW-1:0]  local_frame;
    logic [FrameW-1:0]  confirmed_frame;
    logic [FrameW-1:0]  remote_current;
    logic [FrameW-1:0]  remote_confirmed;
    logic [CountW-1:0]  stop_count;
    logic [CountW-1:0]  rollback_count;
  } item_t;

  typedef struct packed {
    logic              resync_request;
    logic [TimeW-1:0]  stalled_for_ms;
    logic [CountW-1:0] churn;
  } result_t;

  typedef struct packed {
    logic [CfgW-1:0] stall_timeout_ms;
    logic [CfgW-1:0] churn_threshold;
    logic [CfgW-1:0] cooldown_ms;
  } cfg_t;

  function automatic item_t unpack_item(logic [InDataW-1:0] d);
    item_t it;
    it.now_ms           = d[31:0];
    it.session_ok       = d[32];
    it.resync_id        = d[48:33];
    it.pending_acks     = d[56:49];
    it.remote_count     = d[64:57];
    it.epoch            = d[96:65];
    it.local_frame      = d[128:97];
    it.confirmed_frame  = d[160:129];
    it.remote_current   = d[192:161];
    it.remote_confirmed = d[224:193];
    it.stop_count       = d[256:225];
    it.rollback_count   = d[288:257];
    return it;
  endfunction

  function automatic logic [OutDataW-1:0] pack_result(result_t r);
    logic [OutDataW-1:0] d;
    d        = '0;
    d[0]     = r.resync_request;
    d[32:1]  = r.stalled_for_ms;
    d[64:33] = r.churn;
    return d;
  endfunction

endpackage

@@ src/pswd_core.sv @@
module pswd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  pswd_pkg::item_t   item,
  input  pswd_pkg::cfg_t    cfg,
  output pswd_pkg::result_t result
);

  logic                        base_valid_r, base_valid_nxt;
  logic [pswd_pkg::FrameW-1:0] base_epoch_r;
  logic [pswd_pkg::FrameW-1:0] base_local_r;
  logic [pswd_pkg::FrameW-1:0] base_confirmed_r;
  logic [pswd_pkg::FrameW-1:0] base_rcur_r;
  logic [pswd_pkg::FrameW-1:0] base_rconf_r;
  logic [pswd_pkg::CountW-1:0] base_stops_r;
  logic [pswd_pkg::CountW-1:0] base_rollbacks_r;
  logic [pswd_pkg::TimeW-1:0]  last_progress_r, last_progress_nxt;
  logic [pswd_pkg::TimeW-1:0]  cool_until_r, cool_until_nxt;

  logic                        eligible, rebase, progress, in_cool, trip, take_base;
  logic [pswd_pkg::TimeW-1:0]  stall;
  logic [pswd_pkg::CountW-1:0] ds, dr, churn;
  logic [pswd_pkg::TimeW:0]    cool_sum;

  always_comb begin
    eligible = item.session_ok && (item.resync_id == '0) && (item.pending_acks == '0)
               && (item.remote_count != '0);
    rebase   = !base_valid_r || (base_epoch_r != item.epoch);
    progress = (item.local_frame > base_local_r) || (item.confirmed_frame > base_confirmed_r)
               || (item.remote_current > base_rcur_r)
               || (item.remote_confirmed > base_rconf_r);
    in_cool  = item.now_ms < cool_until_r;
    stall    = (item.now_ms >= last_progress_r) ? item.now_ms - last_progress_r : '0;
    ds       = item.stop_count - base_stops_r;
    dr       = item.rollback_count - base_rollbacks_r;
    churn    = (ds > dr) ? ds : dr;
    trip     = (stall >= cfg.stall_timeout_ms) || (churn >= cfg.churn_threshold);
    cool_sum = {1'b0, item.now_ms} + {1'b0, cfg.cooldown_ms};

    result            = '0;
    take_base         = 1'b0;
    base_valid_nxt    = base_valid_r;
    last_progress_nxt = last_progress_r;
    cool_until_nxt    = cool_until_r;

    if (!eligible) begin
      base_valid_nxt    = 1'b0;
      last_progress_nxt = '0;
      cool_until_nxt    = '0;
    end else if (rebase || progress) begin
      take_base = 1'b1;
    end else if (!in_cool && trip) begin
      take_base             = 1'b1;
      result.resync_request = 1'b1;
      result.stalled_for_ms = stall;
      result.churn          = churn;
      cool_until_nxt        = cool_sum[pswd_pkg::TimeW] ? '1 : cool_sum[pswd_pkg::TimeW-1:0];
    end

    if (take_base) begin
      base_valid_nxt    = 1'b1;
      last_progress_nxt = item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_valid_r    <= 1'b0;
      last_progress_r <= '0;
      cool_until_r    <= '0;
    end else if (fire) begin
      base_valid_r    <= base_valid_nxt;
      last_progress_r <= last_progress_nxt;
      cool_until_r    <= cool_until_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && take_base) begin
      base_epoch_r     <= item.epoch;
      base_local_r     <= item.local_frame;
      base_confirmed_r <= item.confirmed_frame;
      base_rcur_r      <= item.remote_current;
      base_rconf_r     <= item.remote_confirmed;
      base_stops_r     <= item.stop_count;
      base_rollbacks_r <= item.rollback_count;
    end
  end

endmodule

@@ src/progress_stall_watchdog_unit.sv @@
// Path: input register, then result register; out_tvalid is set when the result register
// loads the snapshot, which waits while a held result has not been taken.
// Throughput: one snapshot per cycle while the output is not stalled; the baseline,
// progress time and cooldown end are updated in the same cycle that the result register loads.
// Reset: synchronous, active low; clears both stages, the baseline valid flag, the
// progress time and cooldown end, and restores the configuration defaults.
module progress_stall_watchdog_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // now_ms, session_ok, resync_id, pending_acks, remote_count, epoch, local_frame,
  // confirmed_frame, remote_current, remote_confirmed, stop_count, rollback_count
  input  logic [pswd_pkg::InDataW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // resync_request, stalled_for_ms, churn
  output logic [pswd_pkg::OutDataW-1:0]  out_tdata,
  input  logic                           cfg_we,
  input  logic [pswd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pswd_pkg::CfgW-1:0]      cfg_wdata
);

  logic                          in_valid_r;
  logic [pswd_pkg::InDataW-1:0]  in_data_r;
  logic                          out_valid_r;
  logic [pswd_pkg::OutDataW-1:0] out_data_r;
  pswd_pkg::cfg_t                cfg_r;
  pswd_pkg::result_t             result;
  logic                          advance, fire;

  assign advance    = !out_valid_r || out_tready;
  assign fire       = in_valid_r && advance;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  pswd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (pswd_pkg::unpack_item(in_data_r)),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
    if (fire) begin
      out_data_r <= pswd_pkg::pack_result(result);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_timeout_ms <= pswd_pkg::STALL_TIMEOUT_RST;
      cfg_r.churn_threshold  <= pswd_pkg::CHURN_THRESH_RST;
      cfg_r.cooldown_ms      <= pswd_pkg::COOLDOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pswd_pkg::REG_STALL_TIMEOUT: cfg_r.stall_timeout_ms <= cfg_wdata;
        pswd_pkg::REG_CHURN_THRESH:  cfg_r.churn_threshold  <= cfg_wdata;
        pswd_pkg::REG_COOLDOWN:      cfg_r.cooldown_ms      <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

@@ tb/progress_stall_watchdog_unit_tb.sv @@
module progress_stall_watchdog_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pswd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SEG_ITEMS   = 200;
  localparam int unsigned N_SEGS      = 8;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgW-1:0]     cfg_wdata  = '0;

  progress_stall_watchdog_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    item_t   snap;
    bit      typed;
    result_t want;
  } snap_row_t;

  // watchdog model state
  logic        bl_valid        = 1'b0;
  logic [31:0] bl_epoch        = '0;
  logic [31:0] bl_local        = '0;
  logic [31:0] bl_confirmed    = '0;
  logic [31:0] bl_rcur         = '0;
  logic [31:0] bl_rconf        = '0;
  logic [31:0] bl_stops        = '0;
  logic [31:0] bl_rollbacks    = '0;
  logic [31:0] progress_ms     = '0;
  logic [31:0] cooldown_end_ms = '0;
  logic [31:0] timeout_cfg     = STALL_TIMEOUT_RST;
  logic [31:0] churn_cfg       = CHURN_THRESH_RST;
  logic [31:0] cooldown_cfg    = COOLDOWN_RST;

  result_t     verdict_q[$];
  int          fail_count = 0;

  item_t       drive_snap;
  bit          drive_typed = 1'b0;
  result_t     drive_want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  bit [31:0]   sc_now   = 32'd1000;
  bit [31:0]   sc_epoch = 32'd1;
  bit [31:0]   sc_stops = '0;
  bit [31:0]   sc_rolls = '0;
  bit [31:0]   sc_frame [4];
  int unsigned step_max = 100;

  function automatic logic [InDataW-1:0] pack_snapshot(item_t s);
    logic [InDataW-1:0] d;
    d          = '0;
    d[31:0]    = s.now_ms;
    d[32]      = s.session_ok;
    d[48:33]   = s.resync_id;
    d[56:49]   = s.pending_acks;
    d[64:57]   = s.remote_count;
    d[96:65]   = s.epoch;
    d[128:97]  = s.local_frame;
    d[160:129] = s.confirmed_frame;
    d[192:161] = s.remote_current;
    d[224:193] = s.remote_confirmed;
    d[256:225] = s.stop_count;
    d[288:257] = s.rollback_count;
    return d;
  endfunction

  function automatic void rebase(item_t s);
    bl_valid     = 1'b1;
    bl_epoch     = s.epoch;
    bl_local     = s.local_frame;
    bl_confirmed = s.confirmed_frame;
    bl_rcur      = s.remote_current;
    bl_rconf     = s.remote_confirmed;
    bl_stops     = s.stop_count;
    bl_rollbacks = s.rollback_count;
    progress_ms  = s.now_ms;
  endfunction

  function automatic result_t predict_verdict(item_t s);
    result_t     r;
    logic [31:0] stall;
    logic [31:0] ds;
    logic [31:0] dr;
    logic [31:0] churn;
    logic [32:0] end_sum;
    r = '0;
    if (!s.session_ok || s.resync_id != '0 || s.pending_acks != '0 ||
        s.remote_count == '0) begin
      bl_valid        = 1'b0;
      progress_ms     = '0;
      cooldown_end_ms = '0;
      return r;
    end
    if (!bl_valid || bl_epoch != s.epoch) begin
      rebase(s);
      return r;
    end
    if (s.local_frame > bl_local || s.confirmed_frame > bl_confirmed ||
        s.remote_current > bl_rcur || s.remote_confirmed > bl_rconf) begin
      rebase(s);
      return r;
    end
    if (s.now_ms < cooldown_end_ms) return r;
    stall = (s.now_ms >= progress_ms) ? s.now_ms - progress_ms : '0;
    ds    = s.stop_count - bl_stops;
    dr    = s.rollback_count - bl_rollbacks;
    churn = (ds > dr) ? ds : dr;
    if (stall < timeout_cfg && churn < churn_cfg) return r;
    r.resync_request = 1'b1;
    r.stalled_for_ms = stall;
    r.churn          = churn;
    rebase(s);
    end_sum         = {1'b0, s.now_ms} + {1'b0, cooldown_cfg};
    cooldown_end_ms = end_sum[32] ? '1 : end_sum[31:0];
    return r;
  endfunction

  function automatic item_t mk(logic [31:0] now, logic [31:0] ok, logic [31:0] rid,
                               logic [31:0] acks, logic [31:0] rem, logic [31:0] ep,
                               logic [31:0] lf, logic [31:0] cf, logic [31:0] rc,
                               logic [31:0] rcf, logic [31:0] st, logic [31:0] rb);
    item_t s;
    s.now_ms           = now;
    s.session_ok       = ok[0];
    s.resync_id        = rid[15:0];
    s.pending_acks     = acks[7:0];
    s.remote_count     = rem[7:0];
    s.epoch            = ep;
    s.local_frame      = lf;
    s.confirmed_frame  = cf;
    s.remote_current   = rc;
    s.remote_confirmed = rcf;
    s.stop_count       = st;
    s.rollback_count   = rb;
    return s;
  endfunction

  function automatic snap_row_t row(item_t s, logic [31:0] typed, logic [31:0] req,
                                    logic [31:0] st, logic [31:0] ch);
    snap_row_t w;
    w.snap                = s;
    w.typed               = typed[0];
    w.want.resync_request = req[0];
    w.want.stalled_for_ms = st;
    w.want.churn          = ch;
    return w;
  endfunction

  function automatic item_t random_snapshot();
    item_t       s;
    logic [31:0] rnd;
    rnd                = $urandom;
    s.now_ms           = $urandom;
    s.session_ok       = rnd[0];
    s.resync_id        = rnd[16:1];
    s.pending_acks     = rnd[24:17];
    rnd                = $urandom;
    s.remote_count     = rnd[7:0];
    s.epoch            = $urandom;
    s.local_frame      = $urandom;
    s.confirmed_frame  = $urandom;
    s.remote_current   = $urandom;
    s.remote_confirmed = $urandom;
    s.stop_count       = $urandom;
    s.rollback_count   = $urandom;
    if ($urandom_range(99) < 8) return s;
    case ($urandom_range(19))
      0:       sc_now = sc_now - $urandom_range(step_max);
      1:       sc_now = $urandom;
      default: sc_now = sc_now + $urandom_range(step_max);
    endcase
    if ($urandom_range(39) == 0)
      sc_epoch = ($urandom_range(1) != 0) ? $urandom : sc_epoch + 32'd1;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(39))
        0:       sc_frame[k] = sc_frame[k] + $urandom_range(1, 3);
        1:       sc_frame[k] = sc_frame[k] - 32'd1;
        2:       sc_frame[k] = $urandom;
        default: ;
      endcase
    end
    case ($urandom_range(19))
      0, 1, 2: sc_stops = sc_stops + $urandom_range(1, 2);
      3:       sc_stops = $urandom;
      4:       sc_stops = sc_stops - 32'd1;
      default: ;
    endcase
    case ($urandom_range(19))
      0, 1, 2: sc_rolls = sc_rolls + $urandom_range(1, 2);
      3:       sc_rolls = $urandom;
      4:       sc_rolls = sc_rolls - 32'd1;
      default: ;
    endcase
    s.now_ms           = sc_now;
    s.epoch            = sc_epoch;
    s.local_frame      = sc_frame[0];
    s.confirmed_frame  = sc_frame[1];
    s.remote_current   = sc_frame[2];
    s.remote_confirmed = sc_frame[3];
    s.stop_count       = sc_stops;
    s.rollback_count   = sc_rolls;
    s.session_ok       = 1'b1;
    s.resync_id        = '0;
    s.pending_acks     = '0;
    rnd                = $urandom_range(1, 255);
    s.remote_count     = rnd[7:0];
    case ($urandom_range(29))
      0: s.session_ok = 1'b0;
      1: begin
        rnd         = $urandom_range(1, 65535);
        s.resync_id = rnd[15:0];
      end
      2: begin
        rnd            = $urandom_range(1, 255);
        s.pending_acks = rnd[7:0];
      end
      3: s.remote_count = '0;
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_snapshot(input item_t s, input bit typed, input result_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= pack_snapshot(s);
    drive_snap  = s;
    drive_typed = typed;
    drive_want  = want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STALL_TIMEOUT: timeout_cfg  = val;
      REG_CHURN_THRESH:  churn_cfg    = val;
      REG_COOLDOWN:      cooldown_cfg = val;
      default: ;
    endcase
  endtask

  // hold off the receiver on request, otherwise stall at random
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && in_tvalid && in_tready) begin
      want = predict_verdict(drive_snap);
      if (drive_typed) want = drive_want;
      verdict_q.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.resync_request = out_tdata[0];
      got.stalled_for_ms = out_tdata[32:1];
      got.churn          = out_tdata[64:33];
      if (verdict_q.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (got.resync_request !== want.resync_request) begin
          $error("resync_request: expected %0d, got %0d",
                 want.resync_request, got.resync_request);
          fail_count++;
        end
        if (got.stalled_for_ms !== want.stalled_for_ms) begin
          $error("stalled_for_ms: expected %0d, got %0d",
                 want.stalled_for_ms, got.stalled_for_ms);
          fail_count++;
        end
        if (got.churn !== want.churn) begin
          $error("churn: expected %0d, got %0d", want.churn, got.churn);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    snap_row_t   rows[$];
    result_t     none;
    logic [31:0] t_cfg;
    logic [31:0] c_cfg;
    logic [31:0] d_cfg;
    none = '0;
    for (int k = 0; k < 4; k++) sc_frame[k] = 32'd10;
    send_idle_pct = 27;
    recv_idle_pct = 64;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    rows.push_back(row(mk(100, 0, 0, 0, 1, 7, 10, 10, 10, 10, 0, 0), 1, 0, 0, 0));
    rows.push_back(row(mk(1000, 1, 0, 0, 1, 7, 10, 10, 10, 10, 0, 0), 1, 0, 0, 0));
    rows.push_back(row(mk(2000, 1, 0, 0, 1, 7, 10, 10, 10, 10, 0, 0), 1, 0, 0, 0));
    rows.push_back(row(mk(4000, 1, 0, 0, 1, 7, 10, 10, 10, 10, 0, 0), 1, 1, 3000, 0));
    rows.push_back(row(mk(4100, 1, 0, 0, 1, 7, 10, 10, 10, 10, 20, 0), 1, 0, 0, 0));
    rows.push_back(row(mk(9000, 1, 0, 0, 1, 7, 10, 10, 10, 10, 20, 0), 1, 1, 5000, 20));
    rows.push_back(row(mk(20000, 1, 0, 0, 1, 7, 5, 10, 10, 10, 20, 0), 1, 1, 11000, 0));
    rows.push_back(row(mk(21000, 1, 0, 0, 1, 7, 3, 10, 10, 10, 20, 0), 0, 0, 0, 0));
    rows.push_back(row(mk(21500, 1, 0, 0, 1, 7, 4, 10, 10, 10, 20, 0), 0, 0, 0, 0));
    rows.push_back(row(mk(22000, 1, 0, 0, 1, 7, 5, 11, 10, 10, 20, 0), 0, 0, 0, 0));
    rows.push_back(row(mk(30000, 1, 0, 0, 1, 7, 5, 11, 11, 10, 20, 0), 0, 0, 0, 0));
    rows.push_back(row(mk(26000, 1, 0, 0, 1, 7, 5, 11, 11, 10, 28, 0), 1, 1, 0, 8));
    rows.push_back(row(mk(40000, 1, 0, 0, 1, 8, 5, 11, 11, 10, 28, 0), 0, 0, 0, 0));
    rows.push_back(row(mk(40100, 1, 5, 0, 1, 8, 5, 11, 11, 10, 28, 0), 1, 0, 0, 0));
    rows.push_back(row(mk(40200, 1, 0, 3, 1, 8, 5, 11, 11, 10, 28, 0), 1, 0, 0, 0));
    rows.push_back(row(mk(40300, 1, 0, 0, 0, 8, 5, 11, 11, 10, 28, 0), 1, 0, 0, 0));
    rows.push_back(row(mk(50000, 1, 0, 0, 2, 8, 5, 11, 11, 10, 32'hFFFF_FFFF,
                          32'hFFFF_FFF0), 1, 0, 0, 0));
    rows.push_back(row(mk(50001, 1, 0, 0, 2, 8, 5, 11, 11, 10, 2, 5), 1, 1, 1, 21));
    rows.push_back(row(mk(32'hFFFF_F000, 1, 0, 0, 2, 8, 5, 11, 11, 10, 2, 5), 0, 0, 0, 0));
    rows.push_back(row(mk(32'hFFFF_FFFE, 1, 0, 0, 2, 8, 5, 11, 11, 10, 2, 5), 0, 0, 0, 0));
    rows.push_back(row(mk(32'hFFFF_FFFF, 1, 0, 0, 2, 8, 5, 11, 11, 10, 2, 5),
                       1, 1, 32'hFFF, 0));
    rows.push_back(row(mk('1, 1, 32'hFFFF, 32'hFF, 32'hFF, '1, '1, '1, '1, '1, '1, '1),
                       1, 0, 0, 0));
    rows.push_back(row(mk('1, 1, 0, 0, 32'hFF, '1, '1, '1, '1, '1, '1, '1), 1, 0, 0, 0));
    rows.push_back(row(mk(0, 1, 0, 0, 32'hFF, '1, '1, '1, '1, '1, '1, '1), 0, 0, 0, 0));

    foreach (rows[i]) send_snapshot(rows[i].snap, rows[i].typed, rows[i].want);
    drain_results();

    for (int seg = 0; seg < N_SEGS; seg++) begin
      case (seg)
        0: begin
          t_cfg = 500; c_cfg = 6; d_cfg = 800; step_max = 200;
        end
        1: begin
          t_cfg = STALL_TIMEOUT_RST; c_cfg = CHURN_THRESH_RST; d_cfg = COOLDOWN_RST;
          step_max = 1500;
        end
        2: begin
          t_cfg = 1; c_cfg = 1; d_cfg = 0; step_max = 3;
        end
        3: begin
          t_cfg = '1; c_cfg = '1; d_cfg = '1; step_max = 1000;
        end
        4: begin
          t_cfg = 0; c_cfg = 0; d_cfg = 0; step_max = 50;
        end
        5: begin
          t_cfg = $urandom; c_cfg = $urandom; d_cfg = $urandom;
          step_max = $urandom_range(1, 100000);
        end
        6: begin
          t_cfg = $urandom_range(1, 1000); c_cfg = $urandom_range(1, 16);
          d_cfg = $urandom_range(0, 1500); step_max = 400;
        end
        default: begin
          t_cfg = 200; c_cfg = 3; d_cfg = 0; step_max = 120;
        end
      endcase
      if (seg == 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 27;
      end
      if (seg == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_STALL_TIMEOUT, t_cfg);
      write_reg(REG_CHURN_THRESH, c_cfg);
      write_reg(REG_COOLDOWN, d_cfg);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (seg == 1 && n == 60) hold_request = 1'b1;
        if (seg == 4 && n == 100) drain_results();
        send_snapshot(random_snapshot(), 1'b0, none);
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", verdict_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/pswd_pkg.sv
src/pswd_core.sv
src/progress_stall_watchdog_unit.sv
tb/progress_stall_watchdog_unit_tb.sv
